// ----- hdl/deq_pkg.sv -----
// ----------------------------------------------------------------------------
// Double-ended queue package
// Shared sizes, command and status codes, and the cell control word.
// ----------------------------------------------------------------------------
package deq_pkg;

  // Number of cells in the chain and the width of the stored words.
  localparam int unsigned DEPTH  = 16;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned OCC_W  = 5;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  // Word reported when there is nothing to report.
  localparam logic signed [WORD_W-1:0] NEG_ONE = '1;

  // Command codes; the two unused codes act as a status request.
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_REAR  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_REAR   = 3'd3,
    CMD_CLEAR      = 3'd4,
    CMD_STATUS     = 3'd5
  } cmd_e;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // What a cell does with its word this cycle.
  typedef enum logic [1:0] {
    DATA_HOLD,
    DATA_FROM_LEFT,
    DATA_FROM_RIGHT,
    DATA_LOAD_FREE
  } data_op_e;

  // What a cell does with its occupied flag this cycle.
  typedef enum logic [1:0] {
    OCC_HOLD,
    OCC_GROW,
    OCC_SHRINK,
    OCC_CLEAR
  } occ_op_e;

  // Control word broadcast to every cell.
  typedef struct packed {
    data_op_e data_op;
    occ_op_e  occ_op;
  } cell_ctrl_t;

endpackage

// ----- hdl/deq_cell.sv -----
// ----------------------------------------------------------------------------
// Double-ended queue cell
// Holds one word and one occupied flag, and trades words with its neighbors.
// ----------------------------------------------------------------------------
module deq_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  deq_pkg::cell_ctrl_t               ctrl_i,
  input  logic signed [deq_pkg::WORD_W-1:0] value_i,
  input  logic signed [deq_pkg::WORD_W-1:0] left_data_i,
  input  logic signed [deq_pkg::WORD_W-1:0] right_data_i,
  input  logic                              left_occ_i,
  input  logic                              right_occ_i,
  output logic signed [deq_pkg::WORD_W-1:0] data_o,
  output logic                              occ_o,
  output logic                              tail_o
);

  logic signed [deq_pkg::WORD_W-1:0] data_q, data_d;
  logic                              occ_q, occ_d;

  // Next word: shift toward either neighbor, or take the pushed word when this
  // is the first free cell behind the occupied run.
  always_comb begin
    data_d = data_q;
    case (ctrl_i.data_op)
      deq_pkg::DATA_HOLD:       data_d = data_q;
      deq_pkg::DATA_FROM_LEFT:  data_d = left_data_i;
      deq_pkg::DATA_FROM_RIGHT: data_d = right_data_i;
      deq_pkg::DATA_LOAD_FREE: begin
        if (!occ_q && left_occ_i) begin
          data_d = value_i;
        end
      end
      default:                  data_d = data_q;
    endcase
  end

  // The occupied flags form a thermometer code; growing pulls in the left
  // flag and shrinking pulls in the right one.
  always_comb begin
    occ_d = occ_q;
    case (ctrl_i.occ_op)
      deq_pkg::OCC_HOLD:   occ_d = occ_q;
      deq_pkg::OCC_GROW:   occ_d = left_occ_i;
      deq_pkg::OCC_SHRINK: occ_d = right_occ_i;
      deq_pkg::OCC_CLEAR:  occ_d = 1'b0;
      default:             occ_d = occ_q;
    endcase
  end

  // The stored word needs no reset.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  assign data_o = data_q;
  assign occ_o  = occ_q;
  // The last occupied cell holds the rear word.
  assign tail_o = occ_q && !right_occ_i;

endmodule

// ----- hdl/double_ended_queue.sv -----
// ----------------------------------------------------------------------------
// Double-ended queue
// A bounded deque of signed words kept in a chain of cells, front in cell 0.
// ----------------------------------------------------------------------------
//
//   Channel | Handshake              | Word
//   --------+------------------------+---------------------------------------
//   in      | in_valid_i, in_ready_o | cmd_i, value_i
//   out     | out_valid_o, out_ready_i | popped_o, status_o, front_value_o,
//           |                        |   rear_value_o, is_empty_o, occupancy_o
//
// The cells update at the accepting edge and the result is shown from the next
// cycle on, so one word per cycle is sustained while out_ready_i stays high.
// A new command is taken while the result waits only if out_ready_i takes it
// in the same cycle; the cell chain is the single copy of the stored words.
// Reset empties the queue at once; stored words are not cleared.
//
module double_ended_queue (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [deq_pkg::CMD_W-1:0]          cmd_i,
  input  logic signed [deq_pkg::WORD_W-1:0]  value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [deq_pkg::WORD_W-1:0]  popped_o,
  output logic [deq_pkg::STAT_W-1:0]         status_o,
  output logic signed [deq_pkg::WORD_W-1:0]  front_value_o,
  output logic signed [deq_pkg::WORD_W-1:0]  rear_value_o,
  output logic                               is_empty_o,
  output logic [deq_pkg::OCC_W-1:0]          occupancy_o
);

  logic signed [deq_pkg::WORD_W-1:0] cell_data [deq_pkg::DEPTH];
  logic signed [deq_pkg::WORD_W-1:0] left_data [deq_pkg::DEPTH];
  logic signed [deq_pkg::WORD_W-1:0] right_data [deq_pkg::DEPTH];
  logic [deq_pkg::DEPTH-1:0]         cell_occ, cell_tail, left_occ, right_occ;

  deq_pkg::cell_ctrl_t               ctrl;
  logic                              accept;
  logic                              full, empty;
  logic signed [deq_pkg::WORD_W-1:0] rear_word;
  logic signed [deq_pkg::WORD_W-1:0] popped_d, popped_q;
  deq_pkg::status_e                  status_d, status_q;
  logic [deq_pkg::CNT_W-1:0]         count_d, count_q;
  logic                              out_valid_q;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign full       = (count_q == deq_pkg::CNT_W'(deq_pkg::DEPTH));
  assign empty      = (count_q == '0);

  // Neighbor wiring; the front cell sees the pushed word and an occupied left.
  always_comb begin
    for (int i = 0; i < int'(deq_pkg::DEPTH); i++) begin
      if (i == 0) begin
        left_data[i] = value_i;
        left_occ[i]  = 1'b1;
      end else begin
        left_data[i] = cell_data[i-1];
        left_occ[i]  = cell_occ[i-1];
      end
      if (i == int'(deq_pkg::DEPTH) - 1) begin
        right_data[i] = cell_data[i];
        right_occ[i]  = 1'b0;
      end else begin
        right_data[i] = cell_data[i+1];
        right_occ[i]  = cell_occ[i+1];
      end
    end
  end

  // The cell chain.
  for (genvar g = 0; g < int'(deq_pkg::DEPTH); g++) begin : g_cell
    deq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .value_i      (value_i),
      .left_data_i  (left_data[g]),
      .right_data_i (right_data[g]),
      .left_occ_i   (left_occ[g]),
      .right_occ_i  (right_occ[g]),
      .data_o       (cell_data[g]),
      .occ_o        (cell_occ[g]),
      .tail_o       (cell_tail[g])
    );
  end

  // Rear word: only the tail cell contributes.
  always_comb begin
    rear_word = '0;
    for (int i = 0; i < int'(deq_pkg::DEPTH); i++) begin
      rear_word = rear_word | (cell_tail[i] ? cell_data[i] : '0);
    end
  end

  // Command decode into the broadcast cell control, count and result.
  always_comb begin
    ctrl.data_op = deq_pkg::DATA_HOLD;
    ctrl.occ_op  = deq_pkg::OCC_HOLD;
    count_d      = count_q;
    popped_d     = deq_pkg::NEG_ONE;
    status_d     = deq_pkg::ST_OK;
    if (accept) begin
      case (cmd_i)
        deq_pkg::CMD_PUSH_FRONT: begin
          if (full) begin
            status_d = deq_pkg::ST_FULL;
          end else begin
            ctrl.data_op = deq_pkg::DATA_FROM_LEFT;
            ctrl.occ_op  = deq_pkg::OCC_GROW;
            count_d      = count_q + 1'b1;
          end
        end
        deq_pkg::CMD_PUSH_REAR: begin
          if (full) begin
            status_d = deq_pkg::ST_FULL;
          end else begin
            ctrl.data_op = deq_pkg::DATA_LOAD_FREE;
            ctrl.occ_op  = deq_pkg::OCC_GROW;
            count_d      = count_q + 1'b1;
          end
        end
        deq_pkg::CMD_POP_FRONT: begin
          if (empty) begin
            status_d = deq_pkg::ST_EMPTY;
          end else begin
            ctrl.data_op = deq_pkg::DATA_FROM_RIGHT;
            ctrl.occ_op  = deq_pkg::OCC_SHRINK;
            count_d      = count_q - 1'b1;
            popped_d     = cell_data[0];
          end
        end
        deq_pkg::CMD_POP_REAR: begin
          if (empty) begin
            status_d = deq_pkg::ST_EMPTY;
          end else begin
            ctrl.occ_op = deq_pkg::OCC_SHRINK;
            count_d     = count_q - 1'b1;
            popped_d    = rear_word;
          end
        end
        deq_pkg::CMD_CLEAR: begin
          ctrl.occ_op = deq_pkg::OCC_CLEAR;
          count_d     = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Result word registers; the queue view comes from the cells and count.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      popped_q <= popped_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign popped_o      = popped_q;
  assign status_o      = status_q;
  assign front_value_o = cell_occ[0] ? cell_data[0] : deq_pkg::NEG_ONE;
  assign rear_value_o  = empty ? deq_pkg::NEG_ONE : rear_word;
  assign is_empty_o    = empty;
  assign occupancy_o   = deq_pkg::OCC_W'(count_q);

  // The count never passes the number of cells.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= deq_pkg::CNT_W'(deq_pkg::DEPTH))
    else $error("count exceeds depth");

  // The occupied flags agree with the count.
  a_occ_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_occ) == int'(count_q))
    else $error("occupied flags disagree with count");

  // The queue holds still while a result waits.
  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> $stable(count_q) && $stable(cell_occ))
    else $error("queue changed under a stalled result");

  // A push on a full queue is dropped and flagged.
  a_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && full && (cmd_i == deq_pkg::CMD_PUSH_FRONT || cmd_i == deq_pkg::CMD_PUSH_REAR)
    |=> status_q == deq_pkg::ST_FULL && $stable(count_q))
    else $error("push on full queue not dropped");

endmodule
